// ===== rtl/mhsd_pkg.sv =====
// Shared constants and types for the mean half-size downsampler.
package mhsd_pkg;

	localparam int PIX_W  = 16;
	localparam int CFG_W  = 11;
	localparam int IDX_W  = 2;
	localparam int MEAN_W = 19;
	localparam int OUTX_W = 9;
	localparam int OUTY_W = 9;
	localparam int OUTZ_W = 10;

	typedef enum logic [IDX_W-1:0] {
		REG_MODE_3D   = 2'd0,
		REG_IN_WIDTH  = 2'd1,
		REG_IN_HEIGHT = 2'd2,
		REG_IN_DEPTH  = 2'd3
	} cfg_reg_t;

	// Per-voxel block control, produced by the position tracker.
	typedef struct packed {
		logic active;    // voxel lies inside a full block
		logic odd;       // second voxel of an x pair
		logic opens;     // first pair of its block
		logic closes;    // final pair of its block
		logic vol_last;  // block is the last output of the volume
		logic three;     // 2x2x2 averaging in effect
	} blk_ctl_t;

endpackage

// ===== rtl/mhsd_pos.sv =====
// Configuration registers and volume position tracking for the downsampler.
module mhsd_pos import mhsd_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_DEPTH  = 1024,
	localparam int XW        = $clog2(MAX_WIDTH + 1),
	localparam int YW        = $clog2(MAX_HEIGHT + 1),
	localparam int ZW        = $clog2(MAX_DEPTH + 1),
	localparam int HALF_W    = MAX_WIDTH / 2,
	localparam int HALF_H    = MAX_HEIGHT / 2,
	localparam int MEM_DEPTH = HALF_W * HALF_H,
	localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0] wr_data,
	input  logic             step,
	output blk_ctl_t         ctl,
	output logic [XW-2:0]    ox,
	output logic [YW-2:0]    oy,
	output logic [ZW-1:0]    oz,
	output logic [AW-1:0]    addr
);

	localparam logic [CFG_W-1:0] RST_IN_WIDTH  = 11'd1024;
	localparam logic [CFG_W-1:0] RST_IN_HEIGHT = 11'd1024;
	localparam logic [CFG_W-1:0] RST_IN_DEPTH  = 11'd1;
	localparam logic [AW-1:0]    ROW_STRIDE    = AW'(HALF_W);

	logic             mode_q;
	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic [CFG_W-1:0] depth_q;
	logic [XW-1:0]    x_q;
	logic [YW-1:0]    y_q;
	logic [ZW-1:0]    z_q;

	logic [XW-1:0]    w;
	logic [YW-1:0]    h;
	logic [ZW-1:0]    d;
	logic [ZW-1:0]    z_lim;
	logic [ZW-1:0]    dz;
	logic [XW-1:0]    x_inc;
	logic [YW-1:0]    y_inc;
	logic [ZW-1:0]    z_inc;
	logic             three;

	// Clamp the programmed dimensions into the supported range.
	always_comb begin
		if (width_q < CFG_W'(2)) begin
			w = XW'(2);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w = XW'(MAX_WIDTH);
		end else begin
			w = XW'(width_q);
		end
		if (height_q < CFG_W'(2)) begin
			h = YW'(2);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			h = YW'(MAX_HEIGHT);
		end else begin
			h = YW'(height_q);
		end
		if (depth_q == '0) begin
			d = ZW'(1);
		end else if (32'(depth_q) > MAX_DEPTH) begin
			d = ZW'(MAX_DEPTH);
		end else begin
			d = ZW'(depth_q);
		end
	end

	// A single slice falls back to 2x2 averaging.
	assign three = mode_q && (d != ZW'(1));
	assign z_lim = three ? (d & ~ZW'(1)) : d;
	assign dz    = three ? (d >> 1) : d;

	assign ox   = x_q[XW-1:1];
	assign oy   = y_q[YW-1:1];
	assign oz   = three ? (z_q >> 1) : z_q;
	assign addr = AW'(oy) * ROW_STRIDE + AW'(ox);

	always_comb begin
		ctl.active   = (x_q < (w & ~XW'(1))) && (y_q < (h & ~YW'(1))) && (z_q < z_lim);
		ctl.odd      = x_q[0];
		ctl.opens    = !y_q[0] && (!three || !z_q[0]);
		ctl.closes   = y_q[0] && (!three || z_q[0]);
		ctl.vol_last = (ox == w[XW-1:1] - 1'b1) && (oy == h[YW-1:1] - 1'b1)
			&& (oz == dz - ZW'(1));
		ctl.three    = three;
	end

	assign x_inc = x_q + 1'b1;
	assign y_inc = y_q + 1'b1;
	assign z_inc = z_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			width_q  <= RST_IN_WIDTH;
			height_q <= RST_IN_HEIGHT;
			depth_q  <= RST_IN_DEPTH;
			x_q      <= '0;
			y_q      <= '0;
			z_q      <= '0;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_MODE_3D:   mode_q   <= wr_data[0];
				REG_IN_WIDTH:  width_q  <= wr_data;
				REG_IN_HEIGHT: height_q <= wr_data;
				REG_IN_DEPTH:  depth_q  <= wr_data;
				default:       mode_q   <= mode_q;
			endcase
			// restart the volume
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
		end else if (step) begin
			if (x_inc >= w) begin
				x_q <= '0;
				if (y_inc >= h) begin
					y_q <= '0;
					z_q <= (z_inc >= d) ? '0 : z_inc;
				end else begin
					y_q <= y_inc;
				end
			end else begin
				x_q <= x_inc;
			end
		end
	end

endmodule

// ===== rtl/mean_half_size_downsample.sv =====
// Top level of the mean half-size downsampler: 2x2 or 2x2x2 box mean over a voxel stream.
// A closing voxel's result passes the first-stage registers, then the output registers.
// Throughput: one voxel per cycle unless stalled, set by the lone read-modify-write of the
// partial-sum memory (one read port at input transfer, one write port at the first stage).
// Reset: arst_n clears handshakes and position counters, loads config defaults at once;
// the partial-sum memory is not cleared, each entry is written by its block's opening pair.
module mean_half_size_downsample import mhsd_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_DEPTH  = 1024,
	parameter int PIXEL_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_index,
	input  logic [CFG_W-1:0]  wr_data,
	input  logic              pixel_valid,
	output logic              pixel_ready,
	input  logic [PIX_W-1:0]  pixel,
	output logic              result_valid,
	input  logic              result_ready,
	output logic [MEAN_W-1:0] mean_fixed,
	output logic [OUTX_W-1:0] out_x,
	output logic [OUTY_W-1:0] out_y,
	output logic [OUTZ_W-1:0] out_z,
	output logic              last_of_volume
);

	localparam int XW        = $clog2(MAX_WIDTH + 1);
	localparam int YW        = $clog2(MAX_HEIGHT + 1);
	localparam int ZW        = $clog2(MAX_DEPTH + 1);
	localparam int HALF_W    = MAX_WIDTH / 2;
	localparam int HALF_H    = MAX_HEIGHT / 2;
	localparam int MEM_DEPTH = HALF_W * HALF_H;
	localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int PB        = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;
	localparam int SUM_W     = PB + 3;

	blk_ctl_t          ctl;
	logic [XW-2:0]     ox;
	logic [YW-2:0]     oy;
	logic [ZW-1:0]     oz;
	logic [AW-1:0]     addr;

	logic              take;
	logic              adv1;
	logic [PB-1:0]     px;
	logic [PB-1:0]     first_q;

	logic              s1_valid;
	blk_ctl_t          ctl_s1;
	logic [PB:0]       pair_s1;
	logic [SUM_W-1:0]  rd_s1;
	logic [XW-2:0]     ox_s1;
	logic [YW-2:0]     oy_s1;
	logic [ZW-1:0]     oz_s1;
	logic [AW-1:0]     addr_s1;

	logic [SUM_W-1:0]  sum;
	logic [SUM_W:0]    mean_wide;

	logic [SUM_W-1:0]  sum_mem [MEM_DEPTH];

	mhsd_pos #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_DEPTH  (MAX_DEPTH)
	) u_mhsd_pos (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.step     (take),
		.ctl      (ctl),
		.ox       (ox),
		.oy       (oy),
		.oz       (oz),
		.addr     (addr)
	);

	assign px          = pixel[PB-1:0];
	assign adv1        = s1_valid && (!result_valid || result_ready);
	assign pixel_ready = !s1_valid || adv1;
	assign take        = pixel_valid && pixel_ready;

	// Hold the even-column voxel until its partner arrives.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
		end else if (wr_en) begin
			first_q <= '0;
		end else if (take && ctl.active && !ctl.odd) begin
			first_q <= px;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (take) begin
			s1_valid <= 1'b1;
		end else if (adv1) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ctl_s1  <= ctl;
			pair_s1 <= {1'b0, first_q} + {1'b0, px};
			ox_s1   <= ox;
			oy_s1   <= oy;
			oz_s1   <= oz;
			addr_s1 <= addr;
		end
	end

	// Read the running sum as the voxel enters; the previous pair of this
	// block was written back at least one transfer earlier.
	always_ff @(posedge clk) begin
		if (take) begin
			rd_s1 <= sum_mem[addr];
		end
	end

	assign sum       = ctl_s1.opens ? SUM_W'(pair_s1) : rd_s1 + SUM_W'(pair_s1);
	assign mean_wide = ctl_s1.three ? {1'b0, sum} : {sum, 1'b0};

	always_ff @(posedge clk) begin
		if (adv1 && ctl_s1.active && ctl_s1.odd) begin
			sum_mem[addr_s1] <= sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv1) begin
			result_valid <= ctl_s1.active && ctl_s1.odd && ctl_s1.closes;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			mean_fixed     <= MEAN_W'(mean_wide);
			out_x          <= OUTX_W'(ox_s1);
			out_y          <= OUTY_W'(oy_s1);
			out_z          <= OUTZ_W'(oz_s1);
			last_of_volume <= ctl_s1.vol_last;
		end
	end

endmodule

// ===== rtl/mhsd_checker.sv =====
// Port-level checks for the downsampler and their binding to the top level.
module mhsd_checker import mhsd_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              pixel_ready,
	input logic              result_valid,
	input logic              result_ready,
	input logic [MEAN_W-1:0] mean_fixed,
	input logic [OUTX_W-1:0] out_x,
	input logic [OUTY_W-1:0] out_y,
	input logic [OUTZ_W-1:0] out_z,
	input logic              last_of_volume
);

	logic origin_q;

	// After the last block of a volume the next result starts at the origin.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q <= 1'b0;
		end else if (result_valid && result_ready) begin
			origin_q <= last_of_volume;
		end
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(mean_fixed)
			&& $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(last_of_volume))
		else $error("result changed while stalled");

	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel_ready |-> result_valid && !result_ready)
		else $error("input stalled without an output stall");

	a_origin_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && origin_q |-> out_x == '0 && out_y == '0 && out_z == '0)
		else $error("new volume does not start at the origin");

	a_no_input_in_reset_gap: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> pixel_ready && !result_valid)
		else $error("handshake state not cleared by reset");

endmodule

bind mean_half_size_downsample mhsd_checker u_mhsd_checker (.*);

// ===== bench/mhsd_tb_pkg.sv =====
`timescale 1ns / 100ps
// Block-mean predictor and result tracker for the half-size downsampler bench.
package mhsd_tb_pkg;
	import mhsd_pkg::*;

	localparam int DIM_MAX  = 1024;
	localparam int HALF_DIM = DIM_MAX / 2;

	typedef struct packed {
		logic [MEAN_W-1:0] mean;
		logic [OUTX_W-1:0] x;
		logic [OUTY_W-1:0] y;
		logic [OUTZ_W-1:0] z;
		logic              last;
	} block_mean_t;

	class box_mean_tracker;
		logic             mode;
		logic [CFG_W-1:0] width_reg;
		logic [CFG_W-1:0] height_reg;
		logic [CFG_W-1:0] depth_reg;
		int unsigned      block_sums[HALF_DIM * HALF_DIM];
		logic [PIX_W-1:0] even_px;
		int unsigned      col;
		int unsigned      row;
		int unsigned      slc;
		block_mean_t      means_due[$];
		int               mismatches;
		int               voxels_seen;
		int               means_checked;

		function new();
			mode = 1'b0;
			width_reg = CFG_W'(DIM_MAX);
			height_reg = CFG_W'(DIM_MAX);
			depth_reg = CFG_W'(1);
			mismatches = 0;
			voxels_seen = 0;
			means_checked = 0;
			restart();
		endfunction

		function void restart();
			even_px = '0;
			col = 0;
			row = 0;
			slc = 0;
		endfunction

		function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
			if (v < lo) return lo;
			if (v > hi) return hi;
			return v;
		endfunction

		// A register write also restarts the volume position.
		function void set_reg(cfg_reg_t r, logic [CFG_W-1:0] v);
			case (r)
				REG_MODE_3D:   mode = v[0];
				REG_IN_WIDTH:  width_reg = v;
				REG_IN_HEIGHT: height_reg = v;
				REG_IN_DEPTH:  depth_reg = v;
				default: ;
			endcase
			restart();
		endfunction

		function void note_voxel(logic [PIX_W-1:0] px);
			int unsigned w, h, d, w2, h2, dz;
			int unsigned ox, oy, oz, idx, pair, sum;
			bit three, opens, closes, inside_blk;
			block_mean_t m;
			w = clamp(width_reg, 2, DIM_MAX);
			h = clamp(height_reg, 2, DIM_MAX);
			d = clamp(depth_reg, 1, DIM_MAX);
			three = mode && (d >= 2);
			w2 = w / 2;
			h2 = h / 2;
			dz = three ? d / 2 : d;
			voxels_seen++;
			inside_blk = (col < 2 * w2) && (row < 2 * h2) && (three ? slc < 2 * dz : slc < dz);
			if (inside_blk) begin
				if (!col[0]) begin
					even_px = px;
				end else begin
					ox = col >> 1;
					oy = row >> 1;
					oz = three ? slc >> 1 : slc;
					idx = oy * HALF_DIM + ox;
					pair = even_px + px;
					opens = !row[0] && (!three || !slc[0]);
					closes = row[0] && (!three || slc[0]);
					sum = opens ? pair : block_sums[idx] + pair;
					block_sums[idx] = sum;
					if (closes) begin
						m.mean = MEAN_W'(three ? sum : sum * 2);
						m.x = OUTX_W'(ox);
						m.y = OUTY_W'(oy);
						m.z = OUTZ_W'(oz);
						m.last = (ox == w2 - 1) && (oy == h2 - 1) && (oz == dz - 1);
						means_due.push_back(m);
					end
				end
			end
			// advance raster position, wrap at end of volume
			col++;
			if (col >= w) begin
				col = 0;
				row++;
				if (row >= h) begin
					row = 0;
					slc++;
					if (slc >= d) slc = 0;
				end
			end
		endfunction

		function void match_block(block_mean_t got);
			block_mean_t exp_m;
			if (means_due.size() == 0) begin
				$display("%0t: result with none expected, got mean %0d at (%0d,%0d,%0d)",
					$time, got.mean, got.x, got.y, got.z);
				mismatches++;
				return;
			end
			exp_m = means_due.pop_front();
			means_checked++;
			if (got.mean !== exp_m.mean) begin
				$display("%0t: mean_fixed expected %0d actual %0d", $time, exp_m.mean, got.mean);
				mismatches++;
			end
			if (got.x !== exp_m.x) begin
				$display("%0t: out_x expected %0d actual %0d", $time, exp_m.x, got.x);
				mismatches++;
			end
			if (got.y !== exp_m.y) begin
				$display("%0t: out_y expected %0d actual %0d", $time, exp_m.y, got.y);
				mismatches++;
			end
			if (got.z !== exp_m.z) begin
				$display("%0t: out_z expected %0d actual %0d", $time, exp_m.z, got.z);
				mismatches++;
			end
			if (got.last !== exp_m.last) begin
				$display("%0t: last_of_volume expected %0b actual %0b", $time, exp_m.last,
					got.last);
				mismatches++;
			end
		endfunction
	endclass

endpackage

// ===== bench/mean_half_size_downsample_tb.sv =====
`timescale 1ns / 100ps
// Top-level bench for the half-size downsampler: stimulus, handshakes and final check.
module mean_half_size_downsample_tb;
	import mhsd_pkg::*;
	import mhsd_tb_pkg::*;

	localparam int RANDOM_VOXELS = 300;
	localparam int LONG_HOLD     = 80;

	logic              clk;
	logic              arst_n;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_index;
	logic [CFG_W-1:0]  wr_data;
	logic              pixel_valid;
	logic              pixel_ready;
	logic [PIX_W-1:0]  pixel;
	logic              result_valid;
	logic              result_ready;
	logic [MEAN_W-1:0] mean_fixed;
	logic [OUTX_W-1:0] out_x;
	logic [OUTY_W-1:0] out_y;
	logic [OUTZ_W-1:0] out_z;
	logic              last_of_volume;

	box_mean_tracker tracker = new();
	bit calm;
	bit long_hold_req;
	int settings_run;

	mean_half_size_downsample DUT (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.pixel_valid(pixel_valid),
		.pixel_ready(pixel_ready),
		.pixel(pixel),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.mean_fixed(mean_fixed),
		.out_x(out_x),
		.out_y(out_y),
		.out_z(out_z),
		.last_of_volume(last_of_volume)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(5_000_000);
		$display("TB_ERROR");
		$finish;
	end

	// Result side: check every transfer, stall in random bursts.
	initial begin
		int hold;
		int rate;
		int span;
		block_mean_t got;
		hold = 0;
		rate = 0;
		span = 0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && result_ready) begin
				got.mean = mean_fixed;
				got.x = out_x;
				got.y = out_y;
				got.z = out_z;
				got.last = last_of_volume;
				tracker.match_block(got);
			end
			@(negedge clk);
			if (span == 0) begin
				rate = $urandom_range(0, 3);
				span = $urandom_range(20, 120);
			end
			span--;
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold = LONG_HOLD;
			end else if (hold == 0 && !calm && rate != 0 && $urandom_range(1, 8) <= rate) begin
				hold = $urandom_range(1, 14);
			end
			if (hold > 0) begin
				result_ready = 1'b0;
				hold--;
			end else begin
				result_ready = 1'b1;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_voxel(input logic [PIX_W-1:0] v);
		pixel_valid = 1'b1;
		pixel = v;
		do @(posedge clk); while (!pixel_ready);
		tracker.note_voxel(v);
		@(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [CFG_W-1:0] v);
		wr_en = 1'b1;
		wr_index = r;
		wr_data = v;
		@(posedge clk);
		tracker.set_reg(r, v);
		@(negedge clk);
		wr_en = 1'b0;
	endtask

	// Wait out every pending mean plus pipeline slack for voxels that close no block.
	task automatic drain();
		pixel_valid = 1'b0;
		while (tracker.means_due.size() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic configure(input logic [CFG_W-1:0] m, input logic [CFG_W-1:0] w,
			input logic [CFG_W-1:0] h, input logic [CFG_W-1:0] d);
		logic [CFG_W-1:0] vals[4];
		int start;
		cfg_reg_t r;
		drain();
		vals[REG_MODE_3D] = m;
		vals[REG_IN_WIDTH] = w;
		vals[REG_IN_HEIGHT] = h;
		vals[REG_IN_DEPTH] = d;
		start = $urandom_range(0, 3);
		for (int k = 0; k < 4; k++) begin
			r = cfg_reg_t'((start + k) % 4);
			write_reg(r, vals[r]);
		end
		settings_run++;
	endtask

	function automatic logic [PIX_W-1:0] pick_pixel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom());
		endcase
	endfunction

	task automatic stream(input int n, input int gap_rate, input int hold_at);
		for (int i = 0; i < n; i++) begin
			if (i == hold_at) long_hold_req = 1'b1;
			send_voxel(pick_pixel());
			if (!calm && gap_rate != 0 && $urandom_range(1, 8) <= gap_rate) begin
				pixel_valid = 1'b0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
			end
		end
		pixel_valid = 1'b0;
	endtask

	initial begin
		logic [PIX_W-1:0] pix_3d[$];
		logic [PIX_W-1:0] pix_2d[$];
		logic [PIX_W-1:0] pix_flat[$];
		logic [CFG_W-1:0] m, w, h, d;
		int random_voxels;
		int cw, ch, cd, vol, n;

		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		pixel_valid = 1'b0;
		pixel = '0;
		result_ready = 1'b0;
		calm = 1'b0;
		long_hold_req = 1'b0;
		settings_run = 0;
		random_voxels = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// 2x2x2 with an odd trailing row: one full-scale mean, dropped row all zero
		pix_3d = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
			16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000};
		configure(11'h001, 11'd2, 11'd3, 11'd2);
		foreach (pix_3d[i]) send_voxel(pix_3d[i]);
		pixel_valid = 1'b0;

		// sizes below range clamp up; two volumes back to back
		pix_2d = '{16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'hAAAA, 16'h5555, 16'hFFFF, 16'h0001};
		configure(11'h7FE, 11'd0, 11'd1, 11'd0);
		foreach (pix_2d[i]) send_voxel(pix_2d[i]);
		pixel_valid = 1'b0;

		// 3D with a single slice falls back to 2D; odd trailing column
		pix_flat = '{16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0005, 16'h0006};
		configure(11'h001, 11'd3, 11'd2, 11'd1);
		foreach (pix_flat[i]) send_voxel(pix_flat[i]);
		pixel_valid = 1'b0;

		// width clamped down: a full row then the start of the next; hold results off
		// as the first means come out
		configure(11'($urandom_range(0, 2047)), 11'd2047, 11'd0, 11'($urandom_range(0, 1)));
		stream(1040, 0, 1024);

		while (random_voxels < RANDOM_VOXELS) begin
			calm = (random_voxels >= RANDOM_VOXELS - 200);
			m = 11'($urandom_range(0, 2047));
			case ($urandom_range(0, 15))
				0: w = 11'($urandom_range(0, 1));
				1: w = 11'($urandom_range(1025, 2047));
				default: w = 11'($urandom_range(2, 9));
			endcase
			case ($urandom_range(0, 15))
				0: h = 11'($urandom_range(0, 1));
				1: h = 11'($urandom_range(1025, 2047));
				default: h = 11'($urandom_range(2, 7));
			endcase
			case ($urandom_range(0, 15))
				0: d = 11'($urandom_range(0, 1));
				1: d = 11'($urandom_range(1025, 2047));
				default: d = 11'($urandom_range(1, 4));
			endcase
			cw = tracker.clamp(w, 2, DIM_MAX);
			ch = tracker.clamp(h, 2, DIM_MAX);
			cd = tracker.clamp(d, 1, DIM_MAX);
			vol = cw * ch * cd;
			n = vol * $urandom_range(1, 2) + $urandom_range(0, 2 * cw);
			if (n > 240) n = $urandom_range(120, 240);
			configure(m, w, h, d);
			stream(n, calm ? 0 : $urandom_range(0, 3), -1);
			random_voxels += n;
		end

		drain();
		repeat (10) @(negedge clk);
		$display("Streamed %0d voxels under %0d register settings (2D, 3D, clamped sizes).",
			tracker.voxels_seen, settings_run);
		$display("Checked %0d block means, %0d mismatches.", tracker.means_checked,
			tracker.mismatches);
		if (tracker.mismatches == 0 && tracker.means_due.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
